// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the frame decoder.
// No dependencies; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wsfd_pkg.sv =====
// Types and constants of the WebSocket frame decoder.
// No dependencies; used by the channel interfaces, the decoder and the bench.
`timescale 1ns / 1ps
`default_nettype none

package wsfd_pkg;

    // Field widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned OPC_W  = 4;
    localparam int unsigned LEN_W  = 64;

    // First-byte codes
    localparam logic [BYTE_W-1:0] FIN_TEXT  = 8'h81;
    localparam logic [BYTE_W-1:0] FIN_CLOSE = 8'h88;

    // Length-byte codes (mask bit dropped)
    localparam logic [6:0] LEN_MASK = 7'h7F;
    localparam logic [6:0] LEN16    = 7'd126;
    localparam logic [6:0] LEN64    = 7'd127;

    // Opcodes reported
    localparam logic [OPC_W-1:0] OP_TEXT  = 4'd1;
    localparam logic [OPC_W-1:0] OP_CLOSE = 4'd8;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_TEXT_HDR = 2'd1,
        KIND_CLOSE    = 2'd2,
        KIND_OTHER    = 2'd3
    } t_kind;

    // Extended length formats
    typedef enum logic [1:0] {
        LMODE_7  = 2'd0,
        LMODE_16 = 2'd1,
        LMODE_64 = 2'd2
    } t_len_mode;

endpackage

`default_nettype wire

// ===== rtl/wsfd_in_if.sv =====
// Input channel of the frame decoder: one received byte per request.
// Depends on wsfd_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface wsfd_in_if
    import wsfd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              buffer_start;

    modport source (output valid, output in_byte, output buffer_start, input ready);
    modport sink   (input valid, input in_byte, input buffer_start, output ready);
endinterface

`default_nettype wire

// ===== rtl/wsfd_out_if.sv =====
// Result channel of the frame decoder: one decoded result per request.
// Depends on wsfd_pkg for the field widths and the result kind type.
`timescale 1ns / 1ps
`default_nettype none

interface wsfd_out_if
    import wsfd_pkg::*;
();
    logic              valid;
    logic              ready;
    t_kind             out_kind;
    logic [BYTE_W-1:0] out_byte;
    logic [OPC_W-1:0]  opcode;
    logic [LEN_W-1:0]  payload_length;
    logic              last_of_frame;

    modport source (
        output valid, output out_kind, output out_byte, output opcode,
        output payload_length, output last_of_frame, input ready
    );
    modport sink (
        input valid, input out_kind, input out_byte, input opcode,
        input payload_length, input last_of_frame, output ready
    );
endinterface

`default_nettype wire

// ===== rtl/websocket_frame_decoder.sv =====
// Pipeline: an accepted byte goes into the input register, and any result it gives into the result register.
// Throughput: one byte per cycle while the result channel does not stall; the next frame state is
// decoded combinationally between the input register and the result register.
// Reset: synchronous, active low; clears the parser state and both valid
// flags, so the next byte is read as the first byte of a frame.
// Depends on wsfd_pkg, wsfd_in_if, wsfd_out_if and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module websocket_frame_decoder
    import wsfd_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    wsfd_in_if.sink    i_in,
    wsfd_out_if.source o_out
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_LEN  = 3'd1,
        PH_EXT  = 3'd2,
        PH_MASK = 3'd3,
        PH_DATA = 3'd4,
        PH_SKIP = 3'd5
    } t_phase;

    // Input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_start;

    // Frame state
    t_phase            r_phase, n_phase;
    logic [3:0]        r_hdr_cnt, n_hdr_cnt;
    logic [LEN_W-1:0]  r_len, n_len;
    t_len_mode         r_lmode, n_lmode;
    logic [BYTE_W-1:0] r_mask [4];
    logic [BYTE_W-1:0] n_mask [4];
    logic [LEN_W-1:0]  r_idx, n_idx;

    // Result register
    logic              r_out_valid;
    t_kind             r_out_kind, n_out_kind;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic [OPC_W-1:0]  r_out_opc, n_out_opc;
    logic [LEN_W-1:0]  r_out_len, n_out_len;
    logic              r_out_last, n_out_last;
    logic              n_res;

    logic              w_advance;
    logic              w_step;
    logic              w_last;
    logic [6:0]        w_len7;
    logic [3:0]        w_hdr_inc;
    logic [3:0]        w_ext_need;

    // Handshake: the result register frees the input register
    assign w_advance  = !r_out_valid || o_out.ready;
    assign w_step     = r_in_valid && w_advance;
    assign i_in.ready = !r_in_valid || w_advance;

    assign w_len7     = r_in_byte[6:0] & LEN_MASK;
    assign w_hdr_inc  = r_hdr_cnt + 4'd1;
    assign w_ext_need = (r_lmode == LMODE_16) ? 4'd2 : 4'd8;
    assign w_last     = (r_idx + {{(LEN_W-1){1'b0}}, 1'b1}) == r_len;

    // Decode one byte against the frame state
    always_comb begin
        n_phase    = r_phase;
        n_hdr_cnt  = r_hdr_cnt;
        n_len      = r_len;
        n_lmode    = r_lmode;
        n_mask     = r_mask;
        n_idx      = r_idx;
        n_res      = 1'b0;
        n_out_kind = KIND_DATA;
        n_out_byte = '0;
        n_out_opc  = OP_TEXT;
        n_out_len  = '0;
        n_out_last = 1'b1;

        if (r_in_start || r_phase == PH_IDLE) begin
            // First byte of a frame
            n_hdr_cnt = '0;
            n_len     = '0;
            n_lmode   = LMODE_7;
            n_idx     = '0;
            if (r_in_byte == FIN_TEXT) begin
                n_phase = PH_LEN;
            end else begin
                n_phase = PH_SKIP;
                n_res   = 1'b1;
                if (r_in_byte == FIN_CLOSE) begin
                    n_out_kind = KIND_CLOSE;
                    n_out_opc  = OP_CLOSE;
                end else begin
                    n_out_kind = KIND_OTHER;
                    n_out_opc  = r_in_byte[OPC_W-1:0];
                end
            end
        end else begin
            case (r_phase)
                PH_LEN: begin
                    n_hdr_cnt = '0;
                    if (w_len7 == LEN16) begin
                        n_lmode = LMODE_16;
                        n_len   = '0;
                        n_phase = PH_EXT;
                    end else if (w_len7 == LEN64) begin
                        n_lmode = LMODE_64;
                        n_len   = '0;
                        n_phase = PH_EXT;
                    end else begin
                        n_lmode = LMODE_7;
                        n_len   = {{(LEN_W-7){1'b0}}, w_len7};
                        n_phase = PH_MASK;
                    end
                end
                PH_EXT: begin
                    // Shift in big-endian length bytes
                    n_len     = {r_len[LEN_W-BYTE_W-1:0], r_in_byte};
                    n_hdr_cnt = w_hdr_inc;
                    if (w_hdr_inc >= w_ext_need) begin
                        n_hdr_cnt = '0;
                        n_phase   = PH_MASK;
                    end
                end
                PH_MASK: begin
                    n_mask[r_hdr_cnt[1:0]] = r_in_byte;
                    n_hdr_cnt = w_hdr_inc;
                    if (w_hdr_inc >= 4'd4) begin
                        n_hdr_cnt = '0;
                        n_idx     = '0;
                        if (r_len == '0) begin
                            // Empty text frame: report the header alone
                            n_phase    = PH_IDLE;
                            n_res      = 1'b1;
                            n_out_kind = KIND_TEXT_HDR;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    n_res      = 1'b1;
                    n_out_kind = KIND_DATA;
                    n_out_byte = r_in_byte ^ r_mask[r_idx[1:0]];
                    n_out_len  = r_len;
                    n_out_last = w_last;
                    n_idx      = r_idx + {{(LEN_W-1){1'b0}}, 1'b1};
                    if (w_last) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_SKIP;
                end
            endcase
        end
    end

    // Hold state, input register and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_hdr_cnt   <= '0;
            r_len       <= '0;
            r_lmode     <= LMODE_7;
            r_idx       <= '0;
            for (int k = 0; k < 4; k++) begin
                r_mask[k] <= '0;
            end
        end else begin
            // Take a new request when the input register frees up
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            // Advance the frame state
            if (w_step) begin
                r_phase   <= n_phase;
                r_hdr_cnt <= n_hdr_cnt;
                r_len     <= n_len;
                r_lmode   <= n_lmode;
                r_idx     <= n_idx;
                r_mask    <= n_mask;
            end
            // Load or drop the result
            if (w_step && n_res) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        // Payload registers
        if (i_in.valid && i_in.ready) begin
            r_in_byte  <= i_in.in_byte;
            r_in_start <= i_in.buffer_start;
        end
        if (w_step && n_res) begin
            r_out_kind <= n_out_kind;
            r_out_byte <= n_out_byte;
            r_out_opc  <= n_out_opc;
            r_out_len  <= n_out_len;
            r_out_last <= n_out_last;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.out_kind       = r_out_kind;
    assign o_out.out_byte       = r_out_byte;
    assign o_out.opcode         = r_out_opc;
    assign o_out.payload_length = r_out_len;
    assign o_out.last_of_frame  = r_out_last;

    // Checks
    `ASSERT_NXT(a_last_ends_frame, i_clk, i_rst_n, w_step && !r_in_start && r_phase == PH_DATA && w_last, r_phase == PH_IDLE, "last payload byte did not end the frame")
    `ASSERT_IMP(a_mask_count, i_clk, i_rst_n, r_phase == PH_MASK, r_hdr_cnt < 4'd4, "mask byte count out of range")
    `ASSERT_IMP(a_ext_mode, i_clk, i_rst_n, r_phase == PH_EXT, r_lmode == LMODE_16 || r_lmode == LMODE_64, "extended length without an extended mode")
    `ASSERT_IMP(a_hdr_len_zero, i_clk, i_rst_n, r_out_valid && r_out_kind != KIND_DATA, r_out_len == '0 && r_out_byte == '0 && r_out_last, "header result with payload fields set")
    `ASSERT_NXT(a_in_held, i_clk, i_rst_n, r_in_valid && !w_advance, r_in_valid && $stable(r_in_byte) && $stable(r_phase), "stalled byte lost or state moved")

endmodule

`default_nettype wire

// ===== bench/wsfd_frame_checker.sv =====
// Result checker for the WebSocket frame decoder: decodes every accepted byte
// itself and compares each result request with the oldest outstanding prediction.
// Depends on wsfd_pkg, wsfd_in_if and wsfd_out_if.
`timescale 1ns / 1ps

module wsfd_frame_checker
    import wsfd_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    wsfd_in_if          i_in,
    wsfd_out_if         i_res,
    output int unsigned o_fail_count,
    output int unsigned o_pending,
    output int unsigned o_checked
);

    // Header byte counts
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] MASK_BYTES  = 4'd4;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LEN, ST_EXT, ST_MASK, ST_DATA, ST_SKIP
    } t_parse;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data;
        logic [OPC_W-1:0]  opc;
        logic [LEN_W-1:0]  len;
        logic              last;
    } t_result;

    // Shadow frame state
    t_parse            parse_st;
    logic [3:0]        hdr_cnt;
    logic [LEN_W-1:0]  frame_len;
    t_len_mode         len_mode;
    logic [BYTE_W-1:0] mask_key [4];
    logic [LEN_W-1:0]  byte_idx;

    t_result           decoded_q [$];

    // Advance the shadow state by one byte; flag and return any result it gives
    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic start,
                               output logic hit, output t_result res);
        logic [6:0] len7;
        hit = 1'b0;
        res = '0;
        if (start || parse_st == ST_IDLE) begin
            hdr_cnt   = '0;
            frame_len = '0;
            len_mode  = LMODE_7;
            byte_idx  = '0;
            if (b == FIN_TEXT) begin
                parse_st = ST_LEN;
            end else begin
                parse_st = ST_SKIP;
                hit      = 1'b1;
                res.last = 1'b1;
                if (b == FIN_CLOSE) begin
                    res.kind = KIND_CLOSE;
                    res.opc  = OP_CLOSE;
                end else begin
                    res.kind = KIND_OTHER;
                    res.opc  = b[OPC_W-1:0];
                end
            end
        end else begin
            case (parse_st)
                ST_LEN: begin
                    // drop the mask bit, pick the length format
                    len7      = b[6:0] & LEN_MASK;
                    hdr_cnt   = '0;
                    frame_len = '0;
                    if (len7 == LEN16) begin
                        len_mode = LMODE_16;
                        parse_st = ST_EXT;
                    end else if (len7 == LEN64) begin
                        len_mode = LMODE_64;
                        parse_st = ST_EXT;
                    end else begin
                        len_mode  = LMODE_7;
                        frame_len = LEN_W'(len7);
                        parse_st  = ST_MASK;
                    end
                end
                ST_EXT: begin
                    // shift in the big-endian extended length
                    frame_len = {frame_len[LEN_W-BYTE_W-1:0], b};
                    hdr_cnt   = hdr_cnt + 4'd1;
                    if (hdr_cnt >= ((len_mode == LMODE_16) ? EXT16_BYTES : EXT64_BYTES)) begin
                        hdr_cnt  = '0;
                        parse_st = ST_MASK;
                    end
                end
                ST_MASK: begin
                    mask_key[hdr_cnt[1:0]] = b;
                    hdr_cnt = hdr_cnt + 4'd1;
                    if (hdr_cnt >= MASK_BYTES) begin
                        hdr_cnt  = '0;
                        byte_idx = '0;
                        if (frame_len == '0) begin
                            // empty text frame reports its header only
                            parse_st = ST_IDLE;
                            hit      = 1'b1;
                            res.kind = KIND_TEXT_HDR;
                            res.opc  = OP_TEXT;
                            res.last = 1'b1;
                        end else begin
                            parse_st = ST_DATA;
                        end
                    end
                end
                ST_DATA: begin
                    hit      = 1'b1;
                    res.kind = KIND_DATA;
                    res.data = b ^ mask_key[byte_idx[1:0]];
                    res.opc  = OP_TEXT;
                    res.len  = frame_len;
                    res.last = (byte_idx + 1'b1) == frame_len;
                    byte_idx = byte_idx + 1'b1;
                    if (res.last) begin
                        parse_st = ST_IDLE;
                    end
                end
                default: begin
                    parse_st = ST_SKIP;
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [LEN_W-1:0] want,
                               input logic [LEN_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    // Compare result requests first, then predict from the byte request of this edge
    always @(posedge i_clk) begin
        t_result want;
        t_result res;
        logic    hit;
        if (!i_rst_n) begin
            parse_st  = ST_IDLE;
            hdr_cnt   = '0;
            frame_len = '0;
            len_mode  = LMODE_7;
            byte_idx  = '0;
            foreach (mask_key[i]) mask_key[i] = '0;
            decoded_q.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0d byte %0h",
                             $time, i_res.out_kind, i_res.out_byte);
                    o_fail_count++;
                end else begin
                    want = decoded_q.pop_front();
                    check_field("out_kind", LEN_W'(want.kind), LEN_W'(i_res.out_kind));
                    check_field("out_byte", LEN_W'(want.data), LEN_W'(i_res.out_byte));
                    check_field("opcode", LEN_W'(want.opc), LEN_W'(i_res.opcode));
                    check_field("payload_length", want.len, i_res.payload_length);
                    check_field("last_of_frame", LEN_W'(want.last),
                                LEN_W'(i_res.last_of_frame));
                    o_checked++;
                end
            end
            if (i_in.valid && i_in.ready) begin
                decode_byte(i_in.in_byte, i_in.buffer_start, hit, res);
                if (hit) begin
                    decoded_q.push_back(res);
                end
            end
        end
        o_pending = decoded_q.size();
    end

endmodule

// ===== bench/tb_websocket_frame_decoder.sv =====
// Top of the frame decoder bench: clock, reset, byte stimulus, result back-pressure
// and verdict. Depends on wsfd_pkg, both channel interfaces and wsfd_frame_checker.
`timescale 1ns / 1ps

module tb_websocket_frame_decoder;
    import wsfd_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 2000;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 10;

    // Directed opening: bit 8 is the buffer start flag
    localparam logic [8:0] DIRECTED [22] = '{
        9'h1_00, 9'h0_FF,                                   // other opcode, then ignored
        9'h1_88,                                            // close frame
        9'h1_81, 9'h0_80, 9'h0_FF, 9'h0_00, 9'h0_A5, 9'h0_5A, // empty text, mask bit set
        9'h0_81, 9'h0_7E, 9'h0_00, 9'h0_02,                 // 16-bit length, no buffer start
        9'h0_FF, 9'h0_01, 9'h0_80, 9'h0_7F, 9'h0_00, 9'h0_FF,
        9'h0_81, 9'h0_05, 9'h1_88                           // frame cut by a buffer start
    };

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    int unsigned bytes_sent   = 0;
    int unsigned noise_sent   = 0;
    int unsigned frames_sent  = 0;
    int unsigned stall_cycles = 0;
    logic        idle_clean   = 1'b1;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;

    wsfd_in_if  in_ch ();
    wsfd_out_if res_ch ();

    websocket_frame_decoder uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (res_ch)
    );

    wsfd_frame_checker frame_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #5 clk = ~clk;

    // Throttle the result channel
    always @(negedge clk) begin
        res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // End the run if no request moves on either channel for too long
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offer one byte request after a random gap and hold it until taken
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic start);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.in_byte      <= b;
        in_ch.buffer_start <= start;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    // Text frame with random content; long or cut frames leave the decoder mid-frame
    task automatic send_text_frame(input logic start, output logic clean);
        logic [BYTE_W-1:0] frame_q [$];
        logic [LEN_W-1:0]  len;
        logic              mbit;
        int unsigned       sel;
        int unsigned       fmt;
        int unsigned       n_data;
        int unsigned       n_send;
        sel  = $urandom_range(99);
        fmt  = $urandom_range(9);
        mbit = 1'($urandom_range(1));
        if (sel < 4) len = {$urandom, $urandom};
        else if (sel < 10) len = LEN_W'($urandom_range(16'hFFFF));
        else if (sel < 13) len = LEN_W'($urandom_range(125));
        else len = LEN_W'($urandom_range(12));
        frame_q.push_back(FIN_TEXT);
        // shortest length format mostly, a wider one now and then
        if (len > 16'hFFFF || fmt == 0) begin
            frame_q.push_back({mbit, LEN64});
            for (int i = 7; i >= 0; i--) frame_q.push_back(len[8*i +: 8]);
        end else if (len > 125 || fmt == 1) begin
            frame_q.push_back({mbit, LEN16});
            frame_q.push_back(len[15:8]);
            frame_q.push_back(len[7:0]);
        end else begin
            frame_q.push_back({mbit, len[6:0]});
        end
        repeat (4) frame_q.push_back(8'($urandom));
        n_data = (len > 125) ? $urandom_range(8) : int'(len);
        repeat (n_data) frame_q.push_back(8'($urandom));
        n_send = frame_q.size();
        if ($urandom_range(99) < 6) n_send = $urandom_range(frame_q.size() - 1, 1);
        for (int i = 0; i < n_send; i++) send_byte(frame_q[i], (i == 0) ? start : 1'b0);
        clean = (n_send == frame_q.size()) && (LEN_W'(n_data) == len);
    endtask

    // Close or other first byte, then a few bytes the decoder should drop
    task automatic send_control(input logic start);
        logic [BYTE_W-1:0] first;
        first = FIN_CLOSE;
        if ($urandom_range(1) == 1) begin
            first = 8'($urandom);
            while (first == FIN_TEXT) first = 8'($urandom);
        end
        send_byte(first, start);
        repeat ($urandom_range(3)) begin
            send_byte(8'($urandom), 1'b0);
            noise_sent++;
        end
    endtask

    task automatic run_frames(input int unsigned n_items);
        int unsigned goal;
        logic        start;
        goal = bytes_sent - noise_sent + n_items;
        while (bytes_sent - noise_sent < goal) begin
            // a buffer start is needed to leave a cut or skipped frame
            start = !idle_clean || ($urandom_range(1) == 1);
            if ($urandom_range(99) < 80) begin
                send_text_frame(start, idle_clean);
            end else begin
                send_control(start);
                idle_clean = 1'b0;
            end
            frames_sent++;
        end
    endtask

    initial begin
        in_ch.valid        = 1'b0;
        in_ch.in_byte      = '0;
        in_ch.buffer_start = 1'b0;
        res_ch.ready       = 1'b0;
        src_idle_pct       = 19;
        snk_idle_pct       = 50;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
        idle_clean = 1'b0;

        run_frames(RANDOM_ITEMS / 3);
        src_idle_pct = 50;
        snk_idle_pct = 19;
        run_frames(RANDOM_ITEMS / 3);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_frames(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        in_ch.valid <= 1'b0;

        // Drain outstanding results, then give stray ones time to show
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d bytes (%0d dropped after control frames) in %0d random frames;",
                 bytes_sent, noise_sent, frames_sent);
        $display("checked %0d results over three back-pressure patterns.", checked);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
